// File: src/cgsd_pkg.sv
package cgsd_pkg;

  localparam int NumLanes = 4;
  localparam int MaxCurvePoints = 4096;
  localparam int CntW = 13;
  localparam logic [CntW-1:0] CntCap =
    (MaxCurvePoints < 8191) ? CntW'(MaxCurvePoints) : CntW'(8191);
  localparam int QW = 34;  // quotient bits (33-bit magnitude, step >= 1)
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGridStep = 3'd0,
    CfgShift0   = 3'd1,
    CfgShift1   = 3'd2,
    CfgShift2   = 3'd3,
    CfgShift3   = 3'd4,
    CfgDimsUsed = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] coord_0;
    logic signed [31:0] coord_1;
    logic signed [31:0] coord_2;
    logic signed [31:0] coord_3;
    logic               last_point;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] snap_0;
    logic signed [31:0] snap_1;
    logic signed [31:0] snap_2;
    logic signed [31:0] snap_3;
    logic               point_valid;
    logic               curve_end;
    logic [CntW-1:0]    kept_count;
    logic [CntW-1:0]    max_kept;
  } out_item_t;

  // lane control from the top level
  typedef struct packed {
    logic start;
  } lane_ctl_t;

  typedef struct packed {
    logic done;
  } lane_sts_t;

endpackage

// File: src/cgsd_lane.sv
// One coordinate: restoring divide of (2|d|+g) by 2g, one bit per cycle,
// then multiply back and saturate.
module cgsd_lane (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cgsd_pkg::lane_ctl_t   ctl_i,
  input  logic signed [31:0]    coord_i,
  input  logic signed [31:0]    shift_i,
  input  logic [30:0]           step_i,
  output cgsd_pkg::lane_sts_t   sts_o,
  output logic signed [31:0]    snap_o
);

  localparam int QW = cgsd_pkg::QW;

  typedef enum logic [1:0] {StIdle, StDiv, StMul, StOut} state_e;

  state_e            state_q;
  logic [5:0]        cnt_q;
  logic              neg_q;
  logic [QW-1:0]     num_q;   // dividend bits shift out, quotient shifts in
  logic [QW-1:0]     rem_q;
  logic [31:0]       div_q;   // 2g
  logic [30:0]       g_q;
  logic [63:0]       prod_q;
  logic signed [31:0] snap_q;

  logic signed [32:0] diff;
  logic [32:0]        mag;
  logic [30:0]        g_eff;
  logic [QW:0]        trial;
  logic [QW:0]        sub;

  assign diff  = 33'(coord_i) - 33'(shift_i);
  assign mag   = diff[32] ? 33'(-diff) : 33'(diff);
  assign g_eff = (step_i == '0) ? 31'd1 : step_i;
  assign trial = {rem_q, num_q[QW-1]};
  assign sub   = trial - (QW+1)'(div_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (ctl_i.start) begin
            neg_q   <= diff[32];
            num_q   <= QW'({mag, 1'b0}) + QW'(g_eff);
            rem_q   <= '0;
            div_q   <= {g_eff, 1'b0};
            g_q     <= g_eff;
            cnt_q   <= 6'(QW);
            state_q <= StDiv;
          end
        end
        StDiv: begin
          if (!sub[QW]) begin
            rem_q <= sub[QW-1:0];
            num_q <= {num_q[QW-2:0], 1'b1};
          end else begin
            rem_q <= trial[QW-1:0];
            num_q <= {num_q[QW-2:0], 1'b0};
          end
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd1) state_q <= StMul;
        end
        StMul: begin
          // quotient <= 2^33; product of (q clipped) by g saturates anyway
          prod_q  <= (num_q[QW-1:32] != '0) ? 64'hFFFF_FFFF_FFFF_FFFF
                   : 64'(num_q[31:0]) * 64'(g_q);
          state_q <= StOut;
        end
        StOut: begin
          if (neg_q) begin
            snap_q <= (prod_q > 64'h8000_0000) ? 32'sh8000_0000
                    : 32'(-prod_q);
          end else begin
            snap_q <= (prod_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF
                    : 32'(prod_q);
          end
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign sts_o.done = (state_q == StOut);
  assign snap_o     = snap_q;

endmodule

// File: src/cgsd_merge.sv
// Dedup against last kept point, per-curve and running max counts.
module cgsd_merge (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    go_i,
  input  logic [2:0]              dims_i,
  input  logic                    last_i,
  input  logic signed [31:0]      snap_i [cgsd_pkg::NumLanes],
  output logic                    emit_o,
  output cgsd_pkg::out_item_t     res_o
);

  localparam int N = cgsd_pkg::NumLanes;
  localparam int CntW = cgsd_pkg::CntW;

  logic signed [31:0] prev_q [N];
  logic               have_prev_q;
  logic [CntW-1:0]    kept_q, max_q;

  logic signed [31:0] snap_m [N];
  logic               keep;
  logic [CntW-1:0]    kept_n, max_n;

  always_comb begin
    keep = !have_prev_q;
    for (int j = 0; j < N; j++) begin
      snap_m[j] = (3'(j) < dims_i) ? snap_i[j] : 32'sd0;
      // only coordinates in use take part in the repeat test
      if ((3'(j) < dims_i) && (snap_m[j] != prev_q[j])) keep = 1'b1;
    end
    kept_n = kept_q;
    max_n  = max_q;
    if (keep) begin
      if (kept_q < cgsd_pkg::CntCap) kept_n = kept_q + CntW'(1);
      if (kept_n > max_q) max_n = kept_n;
    end
  end

  assign emit_o = go_i && (keep || last_i);

  always_comb begin
    res_o.snap_0      = keep ? snap_m[0] : '0;
    res_o.snap_1      = keep ? snap_m[1] : '0;
    res_o.snap_2      = keep ? snap_m[2] : '0;
    res_o.snap_3      = keep ? snap_m[3] : '0;
    res_o.point_valid = keep;
    res_o.curve_end   = last_i;
    res_o.kept_count  = kept_n;
    res_o.max_kept    = max_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      kept_q      <= '0;
      max_q       <= '0;
      for (int j = 0; j < N; j++) prev_q[j] <= '0;
    end else if (go_i) begin
      if (keep) begin
        for (int j = 0; j < N; j++) prev_q[j] <= snap_m[j];
      end
      max_q <= max_n;
      if (last_i) begin
        have_prev_q <= 1'b0;
        kept_q      <= '0;
      end else begin
        have_prev_q <= have_prev_q | keep;
        kept_q      <= kept_n;
      end
    end
  end

endmodule

// File: src/curve_grid_snap_dedup_unit.sv
// curve_grid_snap_dedup_unit
// Snaps curve points onto a shifted grid and drops repeats of the last
// kept point.
// Channels: in_valid_i/in_ready_o carry one point per beat (in_data_i);
// out_valid_o/out_ready_i carry zero or one result per point (out_data_o);
// cfg_valid_i/cfg_ready_o write register cfg_idx_i with cfg_data_i.
// Four lanes, one per coordinate, each run a 34-step restoring divider
// (one quotient bit per cycle), a multiply stage and a saturate stage.
// The result passes from the divide steps through the multiply and saturate
// stages and the merge into the output register. One point is in the lanes
// at a time, so a new point is taken only once the previous one has been
// merged, and an output stall holds it back further.
// The merge stage compares with the previous kept point and updates the
// counters; a result sits in the output register until taken, while the
// next point is already being accepted and divided.
// If the output register is still full when the lanes finish, the merge
// waits until the receiver takes the beat, and the input stays blocked.
// Reset: grid_step = 1.0, shifts 0, dims_used 2, counters cleared, output
// empty. Config writes are always accepted; write them only when idle.
module curve_grid_snap_dedup_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cgsd_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cgsd_pkg::out_item_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [cgsd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i
);

  localparam int N = cgsd_pkg::NumLanes;

  logic [30:0]        step_q;
  logic signed [31:0] shift_q [N];
  logic [2:0]         dims_q;

  logic               busy_q;   // point in lanes or waiting to merge
  logic               last_q;
  logic               done_q;   // lanes finished, waiting for merge
  logic               out_valid_q;
  cgsd_pkg::out_item_t out_q;

  logic signed [31:0] coord [N];
  logic signed [31:0] snap [N];
  logic               start;
  logic [N-1:0]       lane_done;
  logic               go, emit;
  logic [2:0]         dims_eff;
  cgsd_pkg::out_item_t res;
  cgsd_pkg::lane_ctl_t ctl;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !busy_q;
  assign start       = in_valid_i && in_ready_o;
  assign ctl.start   = start;

  assign coord[0] = in_data_i.coord_0;
  assign coord[1] = in_data_i.coord_1;
  assign coord[2] = in_data_i.coord_2;
  assign coord[3] = in_data_i.coord_3;

  // dims_used of 0 acts as 1, above the lane count as the lane count
  assign dims_eff = (dims_q == 3'd0) ? 3'd1
                  : (dims_q > 3'(N)) ? 3'(N) : dims_q;

  for (genvar j = 0; j < N; j++) begin : g_lane
    cgsd_pkg::lane_sts_t sts;
    cgsd_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .coord_i (coord[j]),
      .shift_i (shift_q[j]),
      .step_i  (step_q),
      .sts_o   (sts),
      .snap_o  (snap[j])
    );
    assign lane_done[j] = sts.done;
  end

  // merge once the lanes are done and the output register can take it
  assign go = done_q && (!out_valid_q || out_ready_i);

  cgsd_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .dims_i (dims_eff),
    .last_i (last_q),
    .snap_i (snap),
    .emit_o (emit),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 31'd65536;
      dims_q      <= 3'd2;
      busy_q      <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < N; j++) shift_q[j] <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_idx_i)
          cgsd_pkg::CfgGridStep: step_q     <= cfg_data_i[30:0];
          cgsd_pkg::CfgShift0:   shift_q[0] <= cfg_data_i;
          cgsd_pkg::CfgShift1:   shift_q[1] <= cfg_data_i;
          cgsd_pkg::CfgShift2:   shift_q[2] <= cfg_data_i;
          cgsd_pkg::CfgShift3:   shift_q[3] <= cfg_data_i;
          cgsd_pkg::CfgDimsUsed: dims_q     <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (start) begin
        busy_q <= 1'b1;
        last_q <= in_data_i.last_point;
      end
      // lanes run in lockstep
      if (&lane_done) done_q <= 1'b1;
      if (go) begin
        done_q <= 1'b0;
        busy_q <= 1'b0;
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (emit) begin
        out_valid_q <= 1'b1;
        out_q       <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: src/cgsd_checker.sv
module cgsd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input cgsd_pkg::out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.point_valid |->
      out_data_o.curve_end && out_data_o.snap_0 == 0 && out_data_o.snap_3 == 0)
    else $error("dropped point result malformed");

  a_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.kept_count <= out_data_o.max_kept)
    else $error("kept count above max");

  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second point taken while busy");

endmodule

bind curve_grid_snap_dedup_unit cgsd_checker u_cgsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
